/* rtl/core/bsdms_pkg.sv */
// Shared constants, types and fixed-point helpers for the scheduler statistics block.
package bsdms_pkg;

  localparam int NumSlots    = 64;
  localparam int SlotW       = 6;
  localparam int FpFrac      = 14;
  localparam int CoefW       = 14;
  localparam int LoadOldCoef = 16110;  // 59/60 in 17.14
  localparam int LoadNewCoef = 273;    // 1/60 in 17.14
  localparam int PriTop      = 63;

  typedef enum logic [2:0] {
    ReqTick    = 3'd0,
    ReqLoad    = 3'd1,
    ReqDecay   = 3'd2,
    ReqReprio  = 3'd3,
    ReqNice    = 3'd4,
    ReqCreate  = 3'd5,
    ReqRemove  = 3'd6,
    ReqQuery   = 3'd7
  } req_e;

  // One entry of the statistics memory
  typedef struct packed {
    logic signed [31:0] rc;
    logic signed [5:0]  nice;
    logic [5:0]         pri;
  } stat_t;

  // round(63 - rc/4 - 2*nice), clamped to 0..63; rc/4 truncates toward zero
  function automatic logic [5:0] calc_priority(input logic signed [31:0] rc,
                                               input logic signed [5:0] nice);
    logic signed [31:0] q4;
    logic signed [35:0] x;
    logic [35:0]        mag;
    logic [21:0]        r;
    logic [5:0]         p;
    q4  = (rc + (rc[31] ? 32'sd3 : 32'sd0)) >>> 2;
    x   = -36'(q4) + ((36'sd63 - (36'(nice) <<< 1)) <<< FpFrac);
    mag = x[35] ? 36'(-x) : 36'(x);
    r   = 22'((mag + 36'd8192) >> FpFrac);
    if (x[35] || (r == 22'd0)) begin
      p = 6'd0;
    end else if (r > 22'(PriTop)) begin
      p = 6'(PriTop);
    end else begin
      p = r[5:0];
    end
    return p;
  endfunction

endpackage

/* rtl/core/bsd_mlfq_scheduler_statistics.sv */
// Top level: MLFQ scheduler statistics in 17.14 fixed point around one statistics memory.
//
// Use: requests enter on the s_axis channel, one transaction per request; the
// kind of request rides in s_axis_tuser. Each request yields exactly one result
// transaction on m_axis describing the addressed slot after the request.
// The idle slot number is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while idle, as the block itself does not enforce this. Steps to m_axis_tvalid:
//   tick, load, nice, create, remove, query: execute, fetch, multiply, output
//   decay all: coefficient divider (one bit per cycle), then read, multiply, write back
//              per slot, then fetch, multiply, output
//   reprioritize all: read and write back per slot, then fetch, multiply, output
// One request is processed at a time; the next one is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// Reset clears live flags, load average and the idle slot (back to 1); the
// memory contents are not cleared, a slot's entry is written on create.
// If the receiver stalls, the result holds in the output register and the
// block parks in its final state until the register frees up.
module bsd_mlfq_scheduler_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // idle_slot
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // thread_slot, nice_value, initial_priority, ready_count
  input  logic [2:0]  s_axis_tuser,    // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // slot_priority, slot_nice, recent_cpu_times100,
                                       // load_avg_times100
  output logic        m_axis_tuser     // slot_live
);
  import bsdms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV, S_P_RD, S_P_MUL, S_P_WR, S_R_WR, S_FETCH, S_MUL, S_OUT
  } state_e;

  state_e state_q;

  // request latched at accept
  req_e             req_q;
  logic [SlotW-1:0] slot_q;
  logic signed [5:0] nice_in_q;
  logic [5:0]       ipri_q;
  logic [6:0]       ready_q;

  logic [SlotW-1:0]  idle_q;
  logic [31:0]       load_q;
  logic [NumSlots-1:0] live_q;
  logic [SlotW-1:0]  idx_q;

  // statistics memory, registered read
  stat_t            mem [NumSlots];
  stat_t            rd_q;
  logic [SlotW-1:0] rd_addr;
  logic             mem_we;
  logic [SlotW-1:0] wr_addr;
  stat_t            wr_data;

  // pass and output datapath registers
  logic signed [47:0] prod_q;
  stat_t              pass_q;
  logic signed [39:0] rcmul_q;
  logic [38:0]        ldmul_q;
  stat_t              res_q;
  logic               res_live_q;

  logic               m_valid_q;
  logic [55:0]        m_data_q;
  logic               m_user_q;

  logic               div_start;
  logic               div_done;
  logic [CoefW-1:0]   coef;

  logic               accept;
  logic               slot_ok;
  logic               slot_live;
  logic               last_idx;
  logic               out_load;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign slot_ok       = int'(slot_q) < NumSlots;
  assign slot_live     = slot_ok && live_q[slot_q];
  assign last_idx      = (idx_q == SlotW'(NumSlots - 1));
  assign div_start     = (state_q == S_EXEC) && (req_q == ReqDecay);
  // result moves into the output register
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  bsdms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .load_i  (load_q),
    .done_o  (div_done),
    .coef_o  (coef)
  );

  // ---- arithmetic ----
  logic signed [32:0] tick_sum;
  logic signed [31:0] tick_rc;
  logic [45:0]        ld_prod;
  logic [7:0]         ld_ready;
  logic [33:0]        ld_sum;
  logic [31:0]        ld_new;
  logic signed [47:0] dec_adj;
  logic signed [35:0] dec_v;
  logic signed [31:0] dec_rc;
  logic [5:0]         pri_exec;
  logic [5:0]         pri_pass;

  always_comb begin
    tick_sum = 33'(rd_q.rc) + 33'sd16384;
    tick_rc  = (tick_sum[32] != tick_sum[31]) ? 32'sh7fffffff : tick_sum[31:0];

    ld_ready = {1'b0, ready_q} + ((slot_q != idle_q) ? 8'd1 : 8'd0);
    ld_prod  = 46'(load_q[30:0]) * 46'(LoadOldCoef);
    ld_sum   = 34'(ld_prod >> FpFrac) + 34'(ld_ready) * 34'(LoadNewCoef);
    ld_new   = (ld_sum > 34'h07fffffff) ? 32'h7fffffff : ld_sum[31:0];

    // truncate toward zero, then add nice in 17.14
    dec_adj = prod_q + (prod_q[47] ? 48'sd16383 : 48'sd0);
    dec_v   = 36'(dec_adj >>> FpFrac) + (36'(pass_q.nice) <<< FpFrac);
    if (dec_v > 36'sh07fffffff) begin
      dec_rc = 32'sh7fffffff;
    end else if (dec_v < -36'sh080000000) begin
      dec_rc = -32'sh80000000;
    end else begin
      dec_rc = dec_v[31:0];
    end

    pri_exec = calc_priority(rd_q.rc, nice_in_q);
    pri_pass = calc_priority(rd_q.rc, rd_q.nice);
  end

  // ---- output rounding ----
  logic [39:0]        rc_mag;
  logic [26:0]        rc_r;
  logic signed [24:0] rc100;
  logic [24:0]        ld_r;
  logic [12:0]        ld100;

  always_comb begin
    rc_mag = rcmul_q[39] ? 40'(-rcmul_q) : 40'(rcmul_q);
    rc_r   = 27'((rc_mag + 40'd8192) >> FpFrac);
    if (!rcmul_q[39]) begin
      rc100 = (rc_r > 27'd13107199) ? 25'sd13107199 : 25'(rc_r);
    end else begin
      rc100 = (rc_r > 27'd13107200) ? -25'sd13107200 : 25'(-$signed(rc_r));
    end
    ld_r  = 25'((ldmul_q + 39'd8192) >> FpFrac);
    ld100 = (ld_r > 25'd8191) ? 13'd8191 : ld_r[12:0];
  end

  // ---- memory port control ----
  always_comb begin
    rd_addr = slot_q;
    mem_we  = 1'b0;
    wr_addr = slot_q;
    wr_data = rd_q;
    case (state_q)
      S_IDLE: rd_addr = s_axis_tdata[SlotW-1:0];
      S_P_RD: rd_addr = idx_q;
      S_EXEC: begin
        case (req_q)
          ReqTick: begin
            mem_we     = slot_live && (slot_q != idle_q);
            wr_data.rc = tick_rc;
          end
          ReqNice: begin
            mem_we       = slot_live;
            wr_data.nice = nice_in_q;
            if (slot_q != idle_q) wr_data.pri = pri_exec;
          end
          ReqCreate: begin
            mem_we       = slot_ok;
            wr_data.rc   = '0;
            wr_data.nice = '0;
            wr_data.pri  = ipri_q;
          end
          default: mem_we = 1'b0;
        endcase
      end
      S_P_WR: begin
        mem_we     = live_q[idx_q];
        wr_addr    = idx_q;
        wr_data    = pass_q;
        wr_data.rc = dec_rc;
      end
      S_R_WR: begin
        mem_we      = live_q[idx_q] && (idx_q != idle_q);
        wr_addr     = idx_q;
        wr_data.pri = pri_pass;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // ---- control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idle_q    <= 6'd1;
      load_q    <= '0;
      live_q    <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
      req_q     <= ReqQuery;
    end else begin
      if (cfg_we_i) idle_q <= cfg_wdata_i;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q   <= req_e'(s_axis_tuser);
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx_q <= '0;
          case (req_q)
            ReqDecay:  state_q <= S_DIV;
            ReqReprio: state_q <= S_P_RD;
            default:   state_q <= S_FETCH;
          endcase
          case (req_q)
            ReqLoad:   load_q <= ld_new;
            ReqCreate: if (slot_ok) live_q[slot_q] <= 1'b1;
            ReqRemove: if (slot_ok) live_q[slot_q] <= 1'b0;
            default:   ;
          endcase
        end
        S_DIV:   if (div_done) state_q <= S_P_RD;
        S_P_RD:  state_q <= (req_q == ReqDecay) ? S_P_MUL : S_R_WR;
        S_P_MUL: state_q <= S_P_WR;
        S_P_WR, S_R_WR: begin
          idx_q   <= idx_q + SlotW'(1);
          state_q <= last_idx ? S_FETCH : S_P_RD;
        end
        S_FETCH: state_q <= S_MUL;
        S_MUL:   state_q <= S_OUT;
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q    <= s_axis_tdata[5:0];
      nice_in_q <= s_axis_tdata[11:6];
      ipri_q    <= s_axis_tdata[17:12];
      ready_q   <= s_axis_tdata[24:18];
    end
    if (state_q == S_P_MUL) begin
      prod_q <= 48'(rd_q.rc) * 48'($signed({1'b0, coef}));
      pass_q <= rd_q;
    end
    if (state_q == S_MUL) begin
      rcmul_q    <= 40'(rd_q.rc) * 40'sd100;
      ldmul_q    <= 39'(load_q[30:0]) * 39'd100;
      res_q      <= rd_q;
      res_live_q <= slot_live;
    end
    if (out_load) begin
      m_user_q <= res_live_q;
      m_data_q <= {6'd0, ld100,
                   res_live_q ? rc100 : 25'sd0,
                   res_live_q ? res_q.nice : 6'sd0,
                   res_live_q ? res_q.pri : 6'd0};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---- assertions ----
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_EXEC || state_q == S_P_WR || state_q == S_R_WR))
    else $error("memory write outside a write state");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted request not executed next cycle");

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[36:0] == 37'd0))
    else $error("non-live slot result carries statistics");

  a_load_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_q[31])
    else $error("load average went negative");

endmodule

/* rtl/core/bsdms_div.sv */
// Iterative divider for the decay coefficient 2L*F/(2L+F), one quotient bit per cycle.
module bsdms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] load_i,
  output logic        done_o,
  output logic [bsdms_pkg::CoefW-1:0] coef_o
);
  import bsdms_pkg::*;

  logic [34:0]      rem_q, rem_d;
  logic [33:0]      dvs_q, dvs_d;
  logic [CoefW-1:0] quo_q, quo_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [34:0]      shl;
  logic             ge;

  // quotient stays below F, so the remainder starts from 2L and only zeros shift in
  assign shl = {rem_q[33:0], 1'b0};
  assign ge  = shl >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {2'b00, load_i, 1'b0};
      dvs_d  = {1'b0, load_i, 1'b0} + 34'd16384;
      quo_d  = '0;
      cnt_d  = 4'(CoefW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (shl - {1'b0, dvs_q}) : shl;
      quo_d = {quo_q[CoefW-2:0], ge};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign coef_o = quo_q;

endmodule
